// ===== design/burst_framer_with_padding_defines.svh =====
// assertion macros shared by the burst framer checker
// no dependencies; expects clk and arst_n in the including scope
`ifndef BURST_FRAMER_WITH_PADDING_DEFINES_SVH
`define BURST_FRAMER_WITH_PADDING_DEFINES_SVH

// same-cycle implication, off during reset
`define BFWP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("burst framer check failed");

// next-cycle implication, off during reset
`define BFWP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("burst framer check failed");

`endif

// ===== design/bfwp_pkg.sv =====
// shared types and constants for the burst framer with padding
// no dependencies
package bfwp_pkg;

	localparam int SAMPLE_BITS      = 16;
	localparam int LENGTH_BITS      = 16;
	localparam int MULT_BITS        = 8;
	localparam int PAD_REG_BITS     = 5;
	localparam int PAD_BITS_DEFAULT = 5;
	localparam int REMAIN_BITS      = 24;
	localparam int CFG_DATA_BITS    = 8;
	localparam int CFG_INDEX_BITS   = 2;

	localparam logic [REMAIN_BITS-1:0] REMAIN_MAX = '1;
	localparam logic signed [SAMPLE_BITS-1:0] PAD_SAMPLE = '0;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_LENGTH_MULT  = 2'd0,
		REG_FRONT_PAD    = 2'd1,
		REG_REAR_PAD     = 2'd2,
		REG_DROP_OUTSIDE = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_i;
		logic signed [SAMPLE_BITS-1:0] sample_q;
		logic                          length_tag_present;
		logic [LENGTH_BITS-1:0]        burst_length;
	} in_beat_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_i;
		logic signed [SAMPLE_BITS-1:0] out_q;
		logic                          start_of_burst;
		logic                          end_of_burst;
		logic                          last_of_run;
	} out_beat_t;

endpackage

// ===== design/burst_framer_with_padding.sv =====
// A beat accepted at the input passes the input stage, the sequencer stage and the output register.
// Throughput (out_ready high): one input beat per cycle while each beat gives one result (or none);
// a beat that opens a burst holds the input for front_pad + 1 output beats (front_pad + 1 + rear_pad
// for a one-sample burst), the closing beat for 1 + rear_pad, one beat per cycle from the sequencer.
// Reset (arst_n low, asynchronous): pipeline empty, not in a burst, registers at defaults.
// depends on bfwp_pkg
module burst_framer_with_padding #(
	parameter int PAD_BITS = bfwp_pkg::PAD_BITS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  bfwp_pkg::in_beat_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output bfwp_pkg::out_beat_t                 out_data,
	input  logic                                cfg_we,
	input  logic [bfwp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [bfwp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import bfwp_pkg::*;

	localparam int PAD_W     = (PAD_BITS < PAD_REG_BITS) ? PAD_BITS : PAD_REG_BITS;
	localparam int PROD_BITS = LENGTH_BITS + MULT_BITS;
	localparam int CMP_BITS  = (PROD_BITS > REMAIN_BITS) ? PROD_BITS : REMAIN_BITS;

	// configuration registers
	logic [MULT_BITS-1:0] mult_q;
	logic [PAD_W-1:0]     front_pad_q;
	logic [PAD_W-1:0]     rear_pad_q;
	logic                 drop_outside_q;

	// burst state
	logic                   active_q;
	logic [REMAIN_BITS-1:0] remain_q;

	// input stage
	logic     valid_s1;
	in_beat_t beat_s1;

	// sequencer stage
	logic                          valid_s2;
	logic [PAD_W-1:0]              front_s2;
	logic [PAD_W-1:0]              rear_s2;
	logic                          pend_s2;
	logic                          sob_s2;
	logic                          eob_s2;
	logic signed [SAMPLE_BITS-1:0] i_s2;
	logic signed [SAMPLE_BITS-1:0] q_s2;

	// output register
	logic      out_valid_q;
	out_beat_t out_data_q;

	// decision signals
	logic [PROD_BITS-1:0]   prod;
	logic [CMP_BITS-1:0]    prod_w;
	logic [REMAIN_BITS-1:0] total;
	logic [REMAIN_BITS-1:0] total_m1;
	logic [REMAIN_BITS-1:0] remain_dec;
	logic                   start;
	logic                   plan_keep;
	logic [PAD_W-1:0]       plan_front;
	logic [PAD_W-1:0]       plan_rear;
	logic                   plan_sob;
	logic                   plan_eob;
	logic                   nxt_active;
	logic [REMAIN_BITS-1:0] nxt_remain;

	// handshake signals
	logic      out_load;
	logic      plan_done;
	logic      s2_free;
	logic      take_s1;
	logic      in_take;
	out_beat_t nxt_beat;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q         <= MULT_BITS'(1);
			front_pad_q    <= '0;
			rear_pad_q     <= '0;
			drop_outside_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_LENGTH_MULT:  mult_q         <= cfg_data[MULT_BITS-1:0];
				REG_FRONT_PAD:    front_pad_q    <= cfg_data[PAD_W-1:0];
				REG_REAR_PAD:     rear_pad_q     <= cfg_data[PAD_W-1:0];
				REG_DROP_OUTSIDE: drop_outside_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// scaled burst length, saturated to the counter width
	assign prod   = PROD_BITS'(beat_s1.burst_length) * PROD_BITS'(mult_q);
	assign prod_w = CMP_BITS'(prod);
	assign total  = (prod_w > CMP_BITS'(REMAIN_MAX)) ? REMAIN_MAX : prod_w[REMAIN_BITS-1:0];
	assign total_m1   = total - REMAIN_BITS'(1);
	assign remain_dec = (remain_q != '0) ? remain_q - REMAIN_BITS'(1) : remain_q;
	assign start      = !active_q && beat_s1.length_tag_present && (total != '0);

	// plan for the beat in the input stage
	always_comb begin
		plan_keep  = 1'b0;
		plan_front = '0;
		plan_rear  = '0;
		plan_sob   = 1'b0;
		plan_eob   = 1'b0;
		nxt_active = active_q;
		nxt_remain = remain_q;
		if (active_q) begin
			plan_keep  = 1'b1;
			nxt_remain = remain_dec;
			if (remain_dec == '0) begin
				nxt_active = 1'b0;
				plan_rear  = rear_pad_q;
				plan_eob   = (rear_pad_q == '0);
			end
		end else if (start) begin
			plan_keep  = 1'b1;
			plan_front = front_pad_q;
			plan_sob   = 1'b1;
			nxt_remain = total_m1;
			if (total_m1 == '0) begin
				nxt_active = 1'b0;
				plan_rear  = rear_pad_q;
				plan_eob   = (rear_pad_q == '0);
			end else begin
				nxt_active = 1'b1;
			end
		end else if (!drop_outside_q) begin
			plan_keep = 1'b1;
		end
	end

	// next output beat from the sequencer: front pads, the sample, rear pads
	always_comb begin
		nxt_beat                = '0;
		nxt_beat.out_i          = PAD_SAMPLE;
		nxt_beat.out_q          = PAD_SAMPLE;
		if (front_s2 != '0) begin
			nxt_beat.start_of_burst = sob_s2;
		end else if (pend_s2) begin
			nxt_beat.out_i          = i_s2;
			nxt_beat.out_q          = q_s2;
			nxt_beat.start_of_burst = sob_s2;
			nxt_beat.end_of_burst   = eob_s2;
			nxt_beat.last_of_run    = (rear_s2 == '0);
		end else begin
			nxt_beat.end_of_burst   = (rear_s2 == PAD_W'(1));
			nxt_beat.last_of_run    = (rear_s2 == PAD_W'(1));
		end
	end

	// handshake chain
	assign out_load  = valid_s2 && (!out_valid_q || out_ready);
	assign plan_done = out_load && nxt_beat.last_of_run;
	assign s2_free   = !valid_s2 || plan_done;
	assign take_s1   = valid_s1 && s2_free;
	assign in_ready  = !valid_s1 || take_s1;
	assign in_take   = in_valid && in_ready;

	// input stage valid and burst state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			active_q <= 1'b0;
			remain_q <= '0;
		end else begin
			if (in_take)
				valid_s1 <= 1'b1;
			else if (take_s1)
				valid_s1 <= 1'b0;
			if (take_s1) begin
				active_q <= nxt_active;
				remain_q <= nxt_remain;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take)
			beat_s1 <= in_data;
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			front_s2 <= '0;
			rear_s2  <= '0;
			pend_s2  <= 1'b0;
			sob_s2   <= 1'b0;
			eob_s2   <= 1'b0;
		end else if (take_s1 && plan_keep) begin
			valid_s2 <= 1'b1;
			front_s2 <= plan_front;
			rear_s2  <= plan_rear;
			pend_s2  <= 1'b1;
			sob_s2   <= plan_sob;
			eob_s2   <= plan_eob;
		end else if (out_load) begin
			sob_s2 <= 1'b0;
			if (plan_done)
				valid_s2 <= 1'b0;
			if (front_s2 != '0)
				front_s2 <= front_s2 - PAD_W'(1);
			else if (pend_s2)
				pend_s2 <= 1'b0;
			else
				rear_s2 <= rear_s2 - PAD_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && plan_keep) begin
			i_s2 <= beat_s1.sample_i;
			q_s2 <= beat_s1.sample_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			out_data_q <= nxt_beat;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== design/bfwp_checker.sv =====
// port-level checks for the burst framer, bound to the top level
// depends on bfwp_pkg and burst_framer_with_padding_defines.svh
`include "burst_framer_with_padding_defines.svh"

module bfwp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input bfwp_pkg::out_beat_t out_data
);
	import bfwp_pkg::*;

	// a stalled result beat holds
	`BFWP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

	// the closing beat of a burst is always the last result of its input
	`BFWP_ASSERT_NOW(a_eob_closes_run, out_valid && out_data.end_of_burst, out_data.last_of_run)

	// nothing pending right after reset
	`BFWP_ASSERT_NOW(a_quiet_after_reset, $rose(arst_n), !out_valid)

endmodule

bind burst_framer_with_padding bfwp_checker u_bfwp_checker (.*);

// ===== sim/tb_top.sv =====
// self-checking testbench for burst_framer_with_padding: directed table, then random phases
// expected beats come from a local framing predictor; depends on bfwp_pkg and the block rtl
`timescale 1ns / 1ps

module tb_top;
	import bfwp_pkg::*;

	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int PHASE_BEATS   = 40;
	localparam int RANDOM_PHASES = 6;
	localparam int IDLE_PCT      = 30;
	localparam int REPORT_CAP    = 50;

	typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                kind;
		cfg_reg_t                 reg_sel;
		logic [CFG_DATA_BITS-1:0] reg_val;
		in_beat_t                 beat;
		bit                       typed;
		out_beat_t                want;
	} stim_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	in_beat_t                  in_data;
	logic                      out_valid;
	logic                      out_ready;
	out_beat_t                 out_data;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	// predictor copy of registers and framing state
	logic [MULT_BITS-1:0]    cur_mult;
	logic [PAD_REG_BITS-1:0] cur_front_pad;
	logic [PAD_REG_BITS-1:0] cur_rear_pad;
	logic                    cur_drop;
	logic [REMAIN_BITS-1:0]  burst_left;
	logic                    burst_open;

	out_beat_t framed_run[$];
	out_beat_t pending_beats[$];

	int mismatch_count = 0;
	int cycle_count = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	burst_framer_with_padding uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic out_beat_t make_out(logic signed [SAMPLE_BITS-1:0] si,
			logic signed [SAMPLE_BITS-1:0] sq, logic sob, logic eob);
		out_beat_t o;
		o.out_i = si;
		o.out_q = sq;
		o.start_of_burst = sob;
		o.end_of_burst = eob;
		o.last_of_run = 1'b0;
		return o;
	endfunction

	// rear pad after the last burst sample, or the end mark on that sample
	task automatic append_rear_pad();
		int n;
		if (cur_rear_pad == 0) begin
			framed_run[framed_run.size()-1].end_of_burst = 1'b1;
		end else begin
			for (n = 0; n < cur_rear_pad; n++)
				framed_run.push_back(make_out(PAD_SAMPLE, PAD_SAMPLE, 1'b0,
					n == cur_rear_pad - 1));
		end
	endtask

	// beats the framer emits for one accepted input beat
	task automatic frame_beat(input in_beat_t b);
		logic [31:0] total;
		int n;
		framed_run.delete();
		if (burst_open) begin
			framed_run.push_back(make_out(b.sample_i, b.sample_q, 1'b0, 1'b0));
			if (burst_left != 0)
				burst_left = burst_left - 1'b1;
			if (burst_left == 0) begin
				burst_open = 1'b0;
				append_rear_pad();
			end
		end else begin
			total = 32'(b.burst_length) * 32'(cur_mult);
			if (total > 32'(REMAIN_MAX))
				total = 32'(REMAIN_MAX);
			if (b.length_tag_present && total != 0) begin
				for (n = 0; n < cur_front_pad; n++)
					framed_run.push_back(make_out(PAD_SAMPLE, PAD_SAMPLE, n == 0, 1'b0));
				framed_run.push_back(make_out(b.sample_i, b.sample_q,
					cur_front_pad == 0, 1'b0));
				burst_left = REMAIN_BITS'(total - 1);
				if (burst_left == 0)
					append_rear_pad();
				else
					burst_open = 1'b1;
			end else if (!cur_drop) begin
				framed_run.push_back(make_out(b.sample_i, b.sample_q, 1'b0, 1'b0));
			end
		end
		if (framed_run.size() > 0)
			framed_run[framed_run.size()-1].last_of_run = 1'b1;
	endtask

	// settle: all expected beats out, then a settling wait for dropped beats in flight
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_BITS-1:0] val);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (sel)
			REG_LENGTH_MULT:  cur_mult = val;
			REG_FRONT_PAD:    cur_front_pad = PAD_REG_BITS'(val);
			REG_REAR_PAD:     cur_rear_pad = PAD_REG_BITS'(val);
			REG_DROP_OUTSIDE: cur_drop = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// offer one input beat after a random gap, then queue what it produces
	task automatic push_beat(input in_beat_t b, input bit typed, input out_beat_t want);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (!in_ready);
		frame_beat(b);
		if (typed)
			pending_beats.push_back(want);
		else
			foreach (framed_run[k]) pending_beats.push_back(framed_run[k]);
	endtask

	// mostly bursts opened by short tags, some zero tags and untagged noise
	function automatic in_beat_t random_beat();
		in_beat_t b;
		int pick;
		b.sample_i = SAMPLE_BITS'($urandom);
		b.sample_q = SAMPLE_BITS'($urandom);
		pick = $urandom_range(99);
		if (burst_open) begin
			b.length_tag_present = 1'($urandom_range(1));
			b.burst_length = LENGTH_BITS'($urandom_range(65535));
		end else if (pick < 70) begin
			b.length_tag_present = 1'b1;
			b.burst_length = LENGTH_BITS'($urandom_range(1, 6));
		end else if (pick < 80) begin
			b.length_tag_present = 1'b1;
			b.burst_length = '0;
		end else begin
			b.length_tag_present = 1'b0;
			b.burst_length = LENGTH_BITS'($urandom_range(65535));
		end
		return b;
	endfunction

	function automatic stim_row_t beat_row(logic [15:0] si, logic [15:0] sq, logic tag,
			logic [15:0] len);
		stim_row_t r;
		r.kind = ROW_BEAT;
		r.reg_sel = REG_LENGTH_MULT;
		r.reg_val = '0;
		r.beat.sample_i = si;
		r.beat.sample_q = sq;
		r.beat.length_tag_present = tag;
		r.beat.burst_length = len;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	// single output beat: the input sample with the given marks, last of run
	function automatic stim_row_t typed_row(logic [15:0] si, logic [15:0] sq, logic tag,
			logic [15:0] len, logic sob, logic eob);
		stim_row_t r;
		r = beat_row(si, sq, tag, len);
		r.typed = 1'b1;
		r.want = make_out(si, sq, sob, eob);
		r.want.last_of_run = 1'b1;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(cfg_reg_t sel, logic [CFG_DATA_BITS-1:0] val);
		stim_row_t r;
		r = beat_row('0, '0, 1'b0, '0);
		r.kind = ROW_CFG;
		r.reg_sel = sel;
		r.reg_val = val;
		return r;
	endfunction

	// receiver: random stalls, one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// output beat check against the oldest expected beat
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_beats.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_CAP)
					$display("%0t: unexpected beat: expected none, got i=%0d q=%0d sob=%b eob=%b last=%b",
						$time, out_data.out_i, out_data.out_q, out_data.start_of_burst,
						out_data.end_of_burst, out_data.last_of_run);
			end else begin
				want = pending_beats.pop_front();
				if (out_data.out_i !== want.out_i || out_data.out_q !== want.out_q ||
						out_data.start_of_burst !== want.start_of_burst ||
						out_data.end_of_burst !== want.end_of_burst ||
						out_data.last_of_run !== want.last_of_run) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_CAP)
						$display("%0t: mismatch: expected i=%0d q=%0d sob=%b eob=%b last=%b, got i=%0d q=%0d sob=%b eob=%b last=%b",
							$time, want.out_i, want.out_q, want.start_of_burst,
							want.end_of_burst, want.last_of_run, out_data.out_i,
							out_data.out_q, out_data.start_of_burst,
							out_data.end_of_burst, out_data.last_of_run);
				end
			end
		end
	end

	// stimulus
	initial begin
		stim_row_t rows[$];
		int p;
		int counted;

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = REG_LENGTH_MULT;
		cfg_data = '0;
		cur_mult = 8'd1;
		cur_front_pad = '0;
		cur_rear_pad = '0;
		cur_drop = 1'b1;
		burst_left = '0;
		burst_open = 1'b0;

		// reset defaults: untagged and zero tags dropped, plain bursts
		rows.push_back(beat_row(16'h7FFF, 16'h8000, 1'b0, 16'hFFFF));
		rows.push_back(beat_row(16'h0001, 16'hFFFF, 1'b1, 16'h0000));
		rows.push_back(typed_row(16'h8000, 16'h7FFF, 1'b1, 16'h0001, 1'b1, 1'b1));
		rows.push_back(beat_row(16'h1234, 16'hEDCB, 1'b1, 16'h0003));
		rows.push_back(typed_row(16'h5555, 16'hAAAA, 1'b1, 16'hFFFF, 1'b0, 1'b0));
		rows.push_back(typed_row(16'hAAAA, 16'h5555, 1'b0, 16'h0000, 1'b0, 1'b1));
		// pass mode, pads with upper data bits set, zero multiplier
		rows.push_back(cfg_row(REG_DROP_OUTSIDE, 8'hFE));
		rows.push_back(cfg_row(REG_FRONT_PAD, 8'hE3));
		rows.push_back(cfg_row(REG_REAR_PAD, 8'hFF));
		rows.push_back(cfg_row(REG_LENGTH_MULT, 8'h00));
		rows.push_back(typed_row(16'hFFFF, 16'h0000, 1'b0, 16'h8000, 1'b0, 1'b0));
		rows.push_back(typed_row(16'h0000, 16'hFFFF, 1'b1, 16'h0005, 1'b0, 1'b0));
		// two-sample burst with front and full rear pad
		rows.push_back(cfg_row(REG_LENGTH_MULT, 8'h02));
		rows.push_back(beat_row(16'h4000, 16'hC000, 1'b1, 16'h0001));
		rows.push_back(beat_row(16'hC000, 16'h4000, 1'b1, 16'h7FFF));
		// single-sample burst with both pads at maximum
		rows.push_back(cfg_row(REG_FRONT_PAD, 8'h1F));
		rows.push_back(cfg_row(REG_LENGTH_MULT, 8'h01));
		rows.push_back(beat_row(16'h7FFF, 16'h7FFF, 1'b1, 16'h0001));
		// no rear pad: end mark on the sample
		rows.push_back(cfg_row(REG_REAR_PAD, 8'h00));
		rows.push_back(beat_row(16'h8000, 16'h8000, 1'b1, 16'h0001));
		// no front pad: start mark on the sample, one rear pad beat
		rows.push_back(cfg_row(REG_DROP_OUTSIDE, 8'h01));
		rows.push_back(cfg_row(REG_FRONT_PAD, 8'h00));
		rows.push_back(cfg_row(REG_REAR_PAD, 8'h01));
		rows.push_back(beat_row(16'h0F0F, 16'hF0F0, 1'b1, 16'h0001));
		rows.push_back(beat_row(16'hF0F0, 16'h0F0F, 1'b0, 16'h1234));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[r]) begin
			if (rows[r].kind == ROW_CFG)
				write_reg(rows[r].reg_sel, rows[r].reg_val);
			else
				push_beat(rows[r].beat, rows[r].typed, rows[r].want);
		end

		// random phases; phase 2 uses a larger multiplier, 3 holds off the
		// receiver, 4 runs without idling
		for (p = 0; p < RANDOM_PHASES; p++) begin
			write_reg(REG_LENGTH_MULT, (p == 2) ? 8'h08 : 8'($urandom_range(1, 4)));
			write_reg(REG_FRONT_PAD, 8'($urandom_range(255)));
			write_reg(REG_REAR_PAD, 8'($urandom_range(255)));
			write_reg(REG_DROP_OUTSIDE, 8'($urandom_range(255)));
			calm = (p == 4);
			if (p == 3)
				hold_req = 1'b1;
			counted = 0;
			while (counted < PHASE_BEATS || burst_open) begin
				push_beat(random_beat(), 1'b0, '0);
				if (framed_run.size() > 0 || burst_open)
					counted++;
			end
		end
		calm = 1'b0;

		// drain and watch for stray beats
		in_valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES * 4) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
